/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_core.
package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int STATUS_W     = 3;
  localparam int OP_W         = 3;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_INS_END   = 3'd2,
    OP_DELETE    = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_COUNT     = 3'd5,
    OP_SORT      = 3'd6,
    OP_DISPLAY   = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Per-cell update selection
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,   // take the request value
    CELL_LEFT,   // take left neighbor (open a gap)
    CELL_RIGHT,  // take right neighbor (close a gap / rotate)
    CELL_HEAD,   // take cell 0 (rotate wrap)
    CELL_MIN,    // lower cell of a compare-swap pair
    CELL_MAX     // upper cell of a compare-swap pair
  } cell_op_t;

endpackage

/* rtl/ple_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one element, updates from its
// neighbors, cell 0 or the request value. Depends on ple_pkg.
module ple_cell (
  input  logic              clk,
  input  ple_pkg::cell_op_t op,
  input  ple_pkg::data_t    load_d,
  input  ple_pkg::data_t    left_d,
  input  ple_pkg::data_t    right_d,
  input  ple_pkg::data_t    head_d,
  output ple_pkg::data_t    data_o
);
  import ple_pkg::*;

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_HOLD:  data_nxt = data_r;
      CELL_LOAD:  data_nxt = load_d;
      CELL_LEFT:  data_nxt = left_d;
      CELL_RIGHT: data_nxt = right_d;
      CELL_HEAD:  data_nxt = head_d;
      CELL_MIN:   data_nxt = (right_d < data_r) ? right_d : data_r;
      CELL_MAX:   data_nxt = (left_d > data_r) ? left_d : data_r;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

/* rtl/positional_list_engine_core.sv */
`timescale 1ns / 1ps
// Top level of the positional list engine: control sequencer plus a row of
// ple_cell instances. Depends on ple_pkg and ple_cell.
//
// Usage:
//   Requests enter on in_operation/in_value/in_position and are taken on a
//   rising edge with start high and busy low. Results leave on out_status,
//   out_element, out_index_or_count and out_last, valid for one cycle while
//   out_valid is high; the receiver has no way to hold them off.
//   Element p (one-based) lives in cell p-1; inserts open a gap by shifting
//   cells one place up, deletes close it by shifting one place down, and both
//   answer in the cycle after the request.
//   Count answers in the next cycle as well.
//   Search and display rotate the occupied cells through cell 0, one per
//   cycle, in S_SCAN with busy high. Display emits one result per cycle
//   from S_SCAN; search answers from S_SCAN when the rotation ends. Sort runs
//   count rounds of odd-even compare-swap between neighbor cells in S_SORT
//   and answers after the last round; lists of zero or one element answer in
//   the next cycle.
//   Empty-list search/display answer in the next cycle.
//   Reset empties the list and returns to idle; cell contents are not reset.
module positional_list_engine_core #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ple_pkg::OP_W-1:0]           in_operation,
  input  logic signed [ple_pkg::DATA_W-1:0]  in_value,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  output logic [ple_pkg::STATUS_W-1:0]       out_status,
  output logic signed [ple_pkg::DATA_W-1:0]  out_element,
  output logic [ple_pkg::POS_W-1:0]          out_index_or_count,
  output logic                               out_last
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SORT} state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        step_r;
  logic                 disp_r;
  logic                 found_r;
  logic [POS_W-1:0]     fidx_r;
  logic                 phase_r;
  data_t                key_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  data_t                out_element_r;
  logic [POS_W-1:0]     out_idx_r;
  logic                 out_last_r;

  cell_op_t   cell_op [CAPACITY];
  data_t      cell_data [CAPACITY];

  logic             accept;
  logic             full;
  logic             is_ins;
  logic             pos_bad_ins;
  logic             do_ins;
  logic             do_del;
  logic [POS_W-1:0] cnt7;
  logic [POS_W-1:0] ins_at;
  logic [POS_W-1:0] del_at;
  logic [CW-1:0]    step_inc;
  logic             step_last;
  logic             head_match;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && (state_r == S_IDLE);
  assign full     = (count_r == CW'(CAPACITY));
  assign cnt7     = POS_W'(count_r);
  assign is_ins   = (in_operation == OP_INS_FRONT) || (in_operation == OP_INS_AT) ||
                    (in_operation == OP_INS_END);
  assign pos_bad_ins = (in_position == '0) || (in_position > cnt7 + POS_W'(1));
  assign do_ins   = accept && is_ins && !full &&
                    !((in_operation == OP_INS_AT) && pos_bad_ins);
  assign do_del   = accept && (in_operation == OP_DELETE) && (count_r != '0) &&
                    (in_position != '0) && (in_position <= cnt7);
  assign del_at   = in_position - POS_W'(1);
  assign step_inc = step_r + CW'(1);
  assign step_last  = (step_inc == count_r);
  assign head_match = (cell_data[0] == key_r);

  always_comb begin
    case (in_operation)
      OP_INS_FRONT: ins_at = '0;
      OP_INS_END:   ins_at = cnt7;
      default:      ins_at = in_position - POS_W'(1);
    endcase
  end

  // Per-cell update selection from the cell's place in the list
  always_comb begin
    logic [POS_W-1:0] idx;
    for (int i = 0; i < CAPACITY; i++) begin
      idx = POS_W'(i);
      cell_op[i] = CELL_HOLD;
      if (do_ins) begin
        if (idx == ins_at) cell_op[i] = CELL_LOAD;
        else if (idx > ins_at && idx <= cnt7) cell_op[i] = CELL_LEFT;
      end else if (do_del) begin
        if (idx >= del_at && idx + POS_W'(1) < cnt7) cell_op[i] = CELL_RIGHT;
      end else if (state_r == S_SCAN) begin
        if (idx + POS_W'(1) < cnt7) cell_op[i] = CELL_RIGHT;
        else if (idx + POS_W'(1) == cnt7) cell_op[i] = CELL_HEAD;
      end else if (state_r == S_SORT) begin
        if (idx[0] == phase_r && idx + POS_W'(1) < cnt7) cell_op[i] = CELL_MIN;
        else if (idx[0] != phase_r && idx != '0 && idx < cnt7) cell_op[i] = CELL_MAX;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ple_cell u_cell (
      .clk     (clk),
      .op      (cell_op[g]),
      .load_d  (in_value),
      .left_d  ((g == 0) ? data_t'('0) : cell_data[(g == 0) ? 0 : g - 1]),
      .right_d ((g == CAPACITY - 1) ? data_t'('0)
                                    : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .head_d  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= 1'b0;
      out_element_r <= '0;
      out_idx_r     <= '0;
      out_last_r    <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            case (in_operation)
              OP_INS_FRONT, OP_INS_AT, OP_INS_END: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_status_r <= ST_FULL;
                end else if (do_ins) begin
                  count_r      <= count_r + CW'(1);
                  out_status_r <= ST_OK;
                end else begin
                  out_status_r <= ST_BADPOS;
                end
              end
              OP_DELETE: begin
                out_valid_r <= 1'b1;
                if (count_r == '0) begin
                  out_status_r <= ST_EMPTY;
                end else if (do_del) begin
                  count_r      <= count_r - CW'(1);
                  out_status_r <= ST_OK;
                end else begin
                  out_status_r <= ST_BADPOS;
                end
              end
              OP_SEARCH, OP_DISPLAY: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_SCAN;
                  disp_r  <= (in_operation == OP_DISPLAY);
                  found_r <= 1'b0;
                  step_r  <= '0;
                  key_r   <= in_value;
                end
              end
              OP_COUNT: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
                out_idx_r    <= cnt7;
              end
              default: begin  // sort
                if (count_r <= CW'(1)) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_OK;
                end else begin
                  state_r <= S_SORT;
                  step_r  <= '0;
                  phase_r <= 1'b0;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          step_r <= step_inc;
          if (disp_r) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= ST_OK;
            out_element_r <= cell_data[0];
            out_last_r    <= step_last;
          end else begin
            if (!found_r && head_match) begin
              found_r <= 1'b1;
              fidx_r  <= POS_W'(step_r) + POS_W'(1);
            end
            if (step_last) begin
              out_valid_r <= 1'b1;
              if (found_r) begin
                out_status_r <= ST_OK;
                out_idx_r    <= fidx_r;
              end else if (head_match) begin
                out_status_r <= ST_OK;
                out_idx_r    <= POS_W'(step_r) + POS_W'(1);
              end else begin
                out_status_r <= ST_NOTFOUND;
              end
            end
          end
          if (step_last) state_r <= S_IDLE;
        end
        S_SORT: begin
          step_r  <= step_inc;
          phase_r <= ~phase_r;
          if (step_last) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_element        = out_element_r;
  assign out_index_or_count = out_idx_r;
  assign out_last           = out_last_r;

endmodule
